// ----- rtl/core/ipxrt_pkg.sv -----
// Types and constants shared by the IPX route table and receive filter.
package ipxrt_pkg;

	localparam int ADDR_W = 48;
	localparam int NET_W = 32;
	localparam int DEV_W = 4;

	localparam logic [15:0] NO_CHECKSUM = 16'hFFFF;
	localparam logic [16:0] PKT_HDR_BYTES = 17'd30;
	localparam logic [3:0] MIN_ADDR_LEN = 4'd2;
	localparam logic [3:0] MAX_ADDR_LEN = 4'd6;
	localparam logic [ADDR_W-1:0] BROADCAST_NODE = {ADDR_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_ADD_DIRECT = 2'd0,
		CMD_ADD_INDIRECT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_RECEIVE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_UNREACH = 4'd1,
		ST_MULTIHOP = 4'd2,
		ST_NODEV = 4'd3,
		ST_BADLEN = 4'd4,
		ST_FULL = 4'd5,
		ST_NOTFOUND = 4'd6,
		ST_BADSUM = 4'd7,
		ST_SMALL = 4'd8,
		ST_HOPS = 4'd9,
		ST_NOROUTE = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_DELIVER = 2'd1,
		ACT_FORWARD = 2'd2
	} action_t;

	// configuration register indexes
	localparam logic CFG_LOCAL_NODE = 1'b0;
	localparam logic CFG_HEADER_LENGTH = 1'b1;

	localparam logic [5:0] HEADER_LENGTH_RESET = 6'd14;

	// one route table entry (the gateway network is never read back, so not kept)
	typedef struct packed {
		logic [NET_W-1:0] net;
		logic [ADDR_W-1:0] gnode;
		logic routed;
		logic blue;
		logic [DEV_W-1:0] dev;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

endpackage

// ----- rtl/core/ipx_route_table_and_rx_filter.sv -----
// IPX route table with receive filter and forwarding decision, single module.
//
// Keeps up to ENTRIES routes, one per network, and serves four commands: add
// direct route, add indirect route (its gateway must be a direct route),
// delete route, and receive packet header. Every command gives exactly one
// result item. A received header is checked for checksum FFFF, minimum size
// (30 + header_length) and hop count, then delivered locally when addressed
// to local_node or broadcast, else forwarded through its route with the hop
// count plus one. Timing: one compare unit walks the table one entry per
// cycle through the registered read port of the route memory, so a command
// that needs the table is captured, scanned over all ENTRIES entries, and
// then decided and written back once the output register is free. A command
// settled by its early checks (bad device or address length, bad header,
// local delivery, hop limit) skips the scan and goes from capture to decide. in_ready is
// high only while no command is in progress; a finished result waits in the
// output register, and the next command may be accepted meanwhile. The
// configuration port writes local_node (index 0) and header_length (index 1)
// at any clock edge with cfg_we high; write it only while the block is idle.
module ipx_route_table_and_rx_filter
	import ipxrt_pkg::*;
#(
	parameter int ENTRIES = 16,
	parameter int MAX_HOPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,
	// command items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] network,
	input  logic [31:0] gateway_network,
	input  logic [47:0] gateway_node,
	input  logic [3:0]  device_index,
	input  logic        device_present,
	input  logic [3:0]  device_addr_len,
	input  logic        bluebook,
	input  logic [15:0] checksum,
	input  logic [15:0] packet_size,
	input  logic [7:0]  hop_count,
	input  logic [47:0] dest_node,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [1:0]  action,
	output logic [4:0]  out_hop_count,
	output logic [3:0]  out_device,
	output logic [47:0] next_hop_node,
	output logic        out_bluebook
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);
	localparam logic [7:0] MAX_HOPS_V = 8'(MAX_HOPS);

	// configuration registers
	logic [47:0] local_node_q;
	logic [5:0]  header_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_node_q <= '0;
			header_length_q <= HEADER_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCAL_NODE:    local_node_q <= cfg_data;
				CFG_HEADER_LENGTH: header_length_q <= cfg_data[5:0];
				default:           ;
			endcase
		end
	end

	// sequencer
	state_t state_q;
	logic   accept;
	logic   out_free;
	logic   advance;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign advance = (state_q == S_DECIDE) && out_free;

	// captured command
	cmd_t        cmd_q;
	logic [31:0] net_q;
	logic [31:0] gnet_q;
	logic [47:0] gnode_q;
	logic [3:0]  dev_q;
	logic        blue_q;
	logic [7:0]  hops_q;
	logic [47:0] dnode_q;

	// early checks done on the incoming item
	logic    pre_done;
	status_t pre_status;
	action_t pre_action;
	logic [16:0] size_min;
	cmd_t    in_cmd;

	logic    pre_done_q;
	status_t pre_status_q;
	action_t pre_action_q;

	assign in_cmd = cmd_t'(command);
	assign size_min = PKT_HDR_BYTES + 17'(header_length_q);

	always_comb begin
		pre_done = 1'b0;
		pre_status = ST_OK;
		pre_action = ACT_NONE;
		unique case (in_cmd)
			CMD_ADD_DIRECT: begin
				if (!device_present) begin
					pre_done = 1'b1;
					pre_status = ST_NODEV;
				end else if (device_addr_len > MAX_ADDR_LEN ||
						device_addr_len < MIN_ADDR_LEN) begin
					pre_done = 1'b1;
					pre_status = ST_BADLEN;
				end
			end
			CMD_ADD_INDIRECT, CMD_DELETE: ;
			CMD_RECEIVE: begin
				pre_done = 1'b1;
				priority if (checksum != NO_CHECKSUM) begin
					pre_status = ST_BADSUM;
				end else if ({1'b0, packet_size} < size_min) begin
					pre_status = ST_SMALL;
				end else if (hop_count > MAX_HOPS_V) begin
					pre_status = ST_HOPS;
				end else if (dest_node == local_node_q || dest_node == BROADCAST_NODE) begin
					pre_action = ACT_DELIVER;
				end else if (hop_count == MAX_HOPS_V) begin
					pre_status = ST_HOPS;
				end else begin
					pre_done = 1'b0;	// needs the route
				end
			end
			default: ;
		endcase
	end

	// route table: valid bits in flops, entries in a memory
	logic [ENTRIES-1:0] route_valid_q;
	entry_t             route_mem_q [ENTRIES];

	// scan counter and read stage
	logic [CW-1:0] cnt_q;
	logic          issue;
	logic          s1_valid_q;
	logic [IW-1:0] idx_s1;
	logic          rv_s1;
	entry_t        rd_s1;

	assign issue = (state_q == S_SCAN) && (cnt_q != LAST_CNT);

	// scan results
	logic          found_q;
	logic [IW-1:0] found_idx_q;
	entry_t        hit_q;
	logic          gfound_q;
	logic          g_routed_q;
	logic          g_blue_q;
	logic [3:0]    g_dev_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	logic net_hit, gw_hit, free_hit;
	assign net_hit = s1_valid_q && rv_s1 && (rd_s1.net == net_q);
	assign gw_hit = s1_valid_q && rv_s1 && (rd_s1.net == gnet_q);
	assign free_hit = s1_valid_q && !rv_s1;

	// decision
	logic          slot_ok;
	logic [IW-1:0] slot_idx;
	logic          wr_en;
	entry_t        wr_entry;
	logic          clr_en;
	status_t       d_status;
	action_t       d_action;
	logic [4:0]    d_hop;
	logic [3:0]    d_dev;
	logic [47:0]   d_nhop;
	logic          d_blue;

	assign slot_ok = found_q || free_found_q;
	assign slot_idx = found_q ? found_idx_q : free_idx_q;

	always_comb begin
		wr_en = 1'b0;
		clr_en = 1'b0;
		wr_entry = '{net: net_q, gnode: '0, routed: 1'b0, blue: blue_q, dev: dev_q};
		d_status = ST_OK;
		d_action = ACT_NONE;
		d_hop = '0;
		d_dev = '0;
		d_nhop = '0;
		d_blue = 1'b0;
		if (pre_done_q) begin
			d_status = pre_status_q;
			d_action = pre_action_q;
		end else begin
			unique case (cmd_q)
				CMD_ADD_DIRECT: begin
					if (!slot_ok) d_status = ST_FULL;
					else wr_en = 1'b1;
				end
				CMD_ADD_INDIRECT: begin
					// gateway fields were captured before any overwrite
					wr_entry = '{net: net_q, gnode: gnode_q, routed: 1'b1,
						blue: g_blue_q, dev: g_dev_q};
					priority if (!gfound_q) d_status = ST_UNREACH;
					else if (g_routed_q) d_status = ST_MULTIHOP;
					else if (!slot_ok) d_status = ST_FULL;
					else wr_en = 1'b1;
				end
				CMD_DELETE: begin
					if (!found_q) d_status = ST_NOTFOUND;
					else clr_en = 1'b1;
				end
				CMD_RECEIVE: begin
					if (!found_q) begin
						d_status = ST_NOROUTE;
					end else begin
						d_action = ACT_FORWARD;
						d_hop = 5'(hops_q + 8'd1);
						d_dev = hit_q.dev;
						d_nhop = hit_q.routed ? hit_q.gnode : dnode_q;
						d_blue = hit_q.blue;
					end
				end
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			s1_valid_q <= 1'b0;
			found_q <= 1'b0;
			gfound_q <= 1'b0;
			free_found_q <= 1'b0;
			pre_done_q <= 1'b0;
			route_valid_q <= '0;
		end else begin
			s1_valid_q <= issue;
			if (issue) cnt_q <= cnt_q + CW'(1);
			if (net_hit) found_q <= 1'b1;
			if (gw_hit) gfound_q <= 1'b1;
			if (free_hit) free_found_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						found_q <= 1'b0;
						gfound_q <= 1'b0;
						free_found_q <= 1'b0;
						pre_done_q <= pre_done;
						state_q <= pre_done ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST_CNT && !s1_valid_q) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (advance) begin
						if (wr_en) route_valid_q[slot_idx] <= 1'b1;
						if (clr_en) route_valid_q[found_idx_q] <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
			net_q <= network;
			gnet_q <= gateway_network;
			gnode_q <= gateway_node;
			dev_q <= device_index;
			blue_q <= bluebook;
			hops_q <= hop_count;
			dnode_q <= dest_node;
			pre_status_q <= pre_status;
			pre_action_q <= pre_action;
		end
		// first hit only; a network is in at most one entry
		if (net_hit && !found_q) begin
			found_idx_q <= idx_s1;
			hit_q <= rd_s1;
		end
		if (gw_hit && !gfound_q) begin
			g_routed_q <= rd_s1.routed;
			g_blue_q <= rd_s1.blue;
			g_dev_q <= rd_s1.dev;
		end
		if (free_hit && !free_found_q) free_idx_q <= idx_s1;
	end

	// route memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (advance && wr_en) route_mem_q[slot_idx] <= wr_entry;
		rd_s1 <= route_mem_q[cnt_q[IW-1:0]];
		idx_s1 <= cnt_q[IW-1:0];
		rv_s1 <= route_valid_q[cnt_q[IW-1:0]];
	end

	// output register
	logic        out_valid_q;
	status_t     status_q;
	action_t     action_q;
	logic [4:0]  hop_q;
	logic [3:0]  odev_q;
	logic [47:0] nhop_q;
	logic        oblue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= d_status;
			action_q <= d_action;
			hop_q <= d_hop;
			odev_q <= d_dev;
			nhop_q <= d_nhop;
			oblue_q <= d_blue;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign action = action_q;
	assign out_hop_count = hop_q;
	assign out_device = odev_q;
	assign next_hop_node = nhop_q;
	assign out_bluebook = oblue_q;

endmodule
